### src/controller_fault_watcher_unit_macros.svh
// assertion macros for the controller fault watcher
`ifndef CONTROLLER_FAULT_WATCHER_UNIT_MACROS_SVH
`define CONTROLLER_FAULT_WATCHER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
`define CFW_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("cfw assertion failed");
`define CFW_ASSERT_NEVER(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("cfw forbidden condition seen");
`else
`define CFW_ASSERT(lbl, prop)
`define CFW_ASSERT_NEVER(lbl, expr)
`endif

`endif

### src/cfw_pkg.sv
package cfw_pkg;

    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_LOW_BATT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HOLD     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_IGNORE   = 2'd2;

    localparam logic [2:0] LOW_BATT_RESET = 3'd1;
    localparam logic [7:0] HOLD_RESET     = 8'd120;
    localparam logic [7:0] IGNORE_RESET   = 8'd90;
    localparam logic [2:0] BATT_RESET     = 3'd4;

    localparam logic [1:0] RS_OK   = 2'd0;
    localparam logic [1:0] RS_DISC = 2'd1;
    localparam logic [1:0] RS_BATT = 2'd2;
    localparam logic [1:0] RS_UNPL = 2'd3;

    localparam logic [2:0] DRV_OTHER     = 3'd0;
    localparam logic [2:0] DRV_FATAL     = 3'd1;
    localparam logic [2:0] DRV_NO_DISK   = 3'd2;
    localparam logic [2:0] DRV_WRONG     = 3'd3;
    localparam logic [2:0] DRV_RETRY     = 3'd4;

    localparam logic [2:0] MSG_NONE       = 3'd0;
    localparam logic [2:0] MSG_UNPLUGGED  = 3'd5;
    localparam logic [2:0] MSG_DISCONNECT = 3'd6;
    localparam logic [2:0] MSG_BATTERY    = 3'd7;

    localparam logic [1:0] PH_CODE_IDLE  = 2'd0;
    localparam logic [1:0] PH_CODE_OPEN  = 2'd1;
    localparam logic [1:0] PH_CODE_SHOW  = 2'd2;
    localparam logic [1:0] PH_CODE_CLOSE = 2'd3;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'b0001,
        PH_OPEN  = 4'b0010,
        PH_SHOW  = 4'b0100,
        PH_CLOSE = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [2:0] low_battery_level;
        logic [7:0] disconnect_hold_ticks;
        logic [7:0] reconnect_ignore_ticks;
    } cfg_t;

    typedef struct packed {
        logic       action;
        logic       permit;
        logic [2:0] drive_status;
        logic       link_up;
        logic       extension_present;
        logic [2:0] battery_reading;
        logic       window_anim_done;
        logic       window_gone;
    } item_t;

    typedef struct packed {
        logic [1:0] window_phase;
        logic [2:0] message_code;
        logic       show_request;
        logic       hide_request;
        logic       audio_enter;
        logic       audio_exit;
        logic       pointer_mode;
    } win_t;

    function automatic logic [1:0] phase_code(input phase_t ph);
        logic [1:0] code;
        unique case (ph)
            PH_IDLE:  code = PH_CODE_IDLE;
            PH_OPEN:  code = PH_CODE_OPEN;
            PH_SHOW:  code = PH_CODE_SHOW;
            PH_CLOSE: code = PH_CODE_CLOSE;
            default:  code = PH_CODE_IDLE;
        endcase
        return code;
    endfunction

endpackage

### src/cfw_cfg_regs.sv
module cfw_cfg_regs
    import cfw_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]             cfg_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg          = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.low_battery_level      <= LOW_BATT_RESET;
            cfg_reg.disconnect_hold_ticks  <= HOLD_RESET;
            cfg_reg.reconnect_ignore_ticks <= IGNORE_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_LOW_BATT: cfg_reg.low_battery_level      <= cfg_data[2:0];
                CFG_HOLD:     cfg_reg.disconnect_hold_ticks  <= cfg_data;
                CFG_IGNORE:   cfg_reg.reconnect_ignore_ticks <= cfg_data;
                default:      ;
            endcase
        end
    end

endmodule

### src/cfw_remote.sv
module cfw_remote
    import cfw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  item_t      item,
    input  cfg_t       cfg,
    output logic [1:0] status_next,
    output logic       prev_permit
);

    logic       mon_reg, mon_next;
    logic       link_prev_reg, link_prev_next;
    logic [7:0] disc_reg, disc_next;
    logic [7:0] ign_reg, ign_next;
    logic [2:0] batt_reg, batt_next;
    logic [1:0] status_reg;
    logic       rising;
    logic [7:0] ign_load;

    always_comb
    begin
        mon_next       = mon_reg;
        link_prev_next = link_prev_reg;
        disc_next      = disc_reg;
        ign_next       = ign_reg;
        batt_next      = batt_reg;
        status_next    = status_reg;
        prev_permit    = 1'b0;
        rising         = item.link_up && !link_prev_reg;
        ign_load       = rising ? cfg.reconnect_ignore_ticks : ign_reg;
        if (item.action)
        begin
            prev_permit = mon_reg;
            mon_next    = item.permit;
            if (item.permit)
                disc_next = 8'd0;
            else
                status_next = RS_OK;
        end
        else if (!mon_reg)
        begin
            status_next = RS_OK;
        end
        else
        begin
            link_prev_next = item.link_up;
            if (item.link_up)
                batt_next = item.battery_reading;
            if (item.link_up)
                disc_next = cfg.disconnect_hold_ticks;
            else if (disc_reg != 8'd0)
                disc_next = disc_reg - 8'd1;
            ign_next = (ign_load != 8'd0) ? ign_load - 8'd1 : 8'd0;
            if (ign_next == 8'd0)
            begin
                if (disc_next == 8'd0)
                    status_next = (batt_next <= cfg.low_battery_level) ? RS_BATT : RS_DISC;
                else if (item.link_up && !item.extension_present)
                    status_next = RS_UNPL;
                else
                    status_next = RS_OK;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mon_reg       <= 1'b0;
            link_prev_reg <= 1'b0;
            disc_reg      <= HOLD_RESET;
            ign_reg       <= 8'd0;
            batt_reg      <= BATT_RESET;
            status_reg    <= RS_OK;
        end
        else if (en)
        begin
            mon_reg       <= mon_next;
            link_prev_reg <= link_prev_next;
            disc_reg      <= disc_next;
            ign_reg       <= ign_next;
            batt_reg      <= batt_next;
            status_reg    <= status_next;
        end
    end

endmodule

### src/cfw_window.sv
`include "controller_fault_watcher_unit_macros.svh"

module cfw_window
    import cfw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  item_t      item,
    input  logic [1:0] status_next,
    output win_t       res
);

    phase_t     phase_reg, phase_next;
    logic [2:0] msg_reg, msg_next;
    logic       first_reg, first_next;
    logic [2:0] pick;

    // drive faults first, then remote status
    always_comb
    begin
        if (item.drive_status == DRV_FATAL || item.drive_status == DRV_NO_DISK ||
            item.drive_status == DRV_WRONG || item.drive_status == DRV_RETRY)
            pick = item.drive_status;
        else
        begin
            case (status_next)
                RS_UNPL: pick = MSG_UNPLUGGED;
                RS_DISC: pick = MSG_DISCONNECT;
                RS_BATT: pick = MSG_BATTERY;
                default: pick = MSG_NONE;
            endcase
        end
    end

    always_comb
    begin
        phase_next       = phase_reg;
        msg_next         = msg_reg;
        first_next       = first_reg;
        res.show_request = 1'b0;
        res.hide_request = 1'b0;
        res.audio_enter  = 1'b0;
        res.audio_exit   = 1'b0;
        res.pointer_mode = 1'b0;
        if (!item.action)
        begin
            first_next = 1'b0;
            unique case (phase_reg)
                PH_IDLE:
                begin
                    if (pick != MSG_NONE)
                    begin
                        msg_next        = pick;
                        phase_next      = PH_OPEN;
                        first_next      = 1'b1;
                        res.audio_enter = 1'b1;
                    end
                end
                PH_OPEN:
                begin
                    res.show_request = first_reg;
                    res.pointer_mode = 1'b1;
                    if (item.window_anim_done)
                    begin
                        phase_next = PH_SHOW;
                        first_next = 1'b1;
                    end
                end
                PH_SHOW:
                begin
                    res.pointer_mode = 1'b1;
                    if (pick == MSG_NONE)
                    begin
                        phase_next       = PH_CLOSE;
                        first_next       = 1'b1;
                        msg_next         = MSG_NONE;
                        res.hide_request = 1'b1;
                    end
                    else if (pick != msg_reg)
                    begin
                        msg_next   = pick;
                        phase_next = PH_OPEN;
                        first_next = 1'b1;
                    end
                end
                PH_CLOSE:
                begin
                    if (item.window_gone)
                    begin
                        first_next = 1'b1;
                        if (pick != MSG_NONE)
                        begin
                            msg_next   = pick;
                            phase_next = PH_OPEN;
                        end
                        else
                        begin
                            phase_next     = PH_IDLE;
                            res.audio_exit = 1'b1;
                        end
                    end
                    else
                        res.pointer_mode = 1'b1;
                end
                default: ;
            endcase
        end
        res.window_phase = phase_code(phase_next);
        res.message_code = msg_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            msg_reg   <= MSG_NONE;
            first_reg <= 1'b1;
        end
        else if (en)
        begin
            phase_reg <= phase_next;
            msg_reg   <= msg_next;
            first_reg <= first_next;
        end
    end

    `CFW_ASSERT(a_phase_onehot, $onehot(phase_reg))
    `CFW_ASSERT(a_idle_no_msg, (phase_reg == PH_IDLE) |-> (msg_reg == MSG_NONE))
    `CFW_ASSERT(a_open_has_msg, (phase_reg == PH_OPEN || phase_reg == PH_SHOW) |-> (msg_reg != MSG_NONE))
    `CFW_ASSERT(a_hide_closes, (en && res.hide_request) |=> (phase_reg == PH_CLOSE && first_reg))

endmodule

### src/controller_fault_watcher_unit.sv
// controller fault watcher
// input channel: in_valid/in_stall with one item per transfer (tick or
// set-permission); output channel: out_valid/out_stall with one result per item
// configuration: cfg_valid/cfg_ready write port, cfg_index selects low battery
// level, disconnect hold or reconnect ignore, cfg_data carries the value;
// the user must make writes only while no item is in flight; the block does not enforce it
// an item is held in the input register, and its result is registered in the result
// register, from which it is shown on the output channel
// throughput: one item per cycle when not stalled; the input register and the
// result register each hold one item, state is updated as an item moves between
// them; a stalled result holds in the result register while the next item
// waits in the input register; in_stall rises only when both are full
// reset: all state and the valid bits return to their reset values at once, no
// item is held, both channels are empty; the item and result data are not reset
module controller_fault_watcher_unit
    import cfw_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   action,
    input  logic                   permit,
    input  logic [2:0]             drive_status,
    input  logic                   link_up,
    input  logic                   extension_present,
    input  logic [2:0]             battery_reading,
    input  logic                   window_anim_done,
    input  logic                   window_gone,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [1:0]             window_phase,
    output logic [2:0]             message_code,
    output logic                   show_request,
    output logic                   hide_request,
    output logic                   audio_fault_enter,
    output logic                   audio_fault_exit,
    output logic                   pointer_fault_mode,
    output logic [1:0]             remote_status,
    output logic                   previous_permit,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]             cfg_data
);

    cfg_t       cfg;
    item_t      item_reg;
    logic       item_valid_reg;
    logic       move;
    logic [1:0] status_next;
    logic       prev_permit;
    win_t       win;

    win_t       win_reg;
    logic [1:0] status_out_reg;
    logic       permit_out_reg;
    logic       out_valid_reg;

    assign move     = item_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = item_valid_reg && !move;

    cfw_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    cfw_remote u_remote (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (move),
        .item        (item_reg),
        .cfg         (cfg),
        .status_next (status_next),
        .prev_permit (prev_permit)
    );

    cfw_window u_window (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (move),
        .item        (item_reg),
        .status_next (status_next),
        .res         (win)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (!in_stall)
            item_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            item_reg.action            <= action;
            item_reg.permit            <= permit;
            item_reg.drive_status      <= drive_status;
            item_reg.link_up           <= link_up;
            item_reg.extension_present <= extension_present;
            item_reg.battery_reading   <= battery_reading;
            item_reg.window_anim_done  <= window_anim_done;
            item_reg.window_gone       <= window_gone;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (!out_valid_reg || !out_stall)
            out_valid_reg <= item_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (move)
        begin
            win_reg        <= win;
            status_out_reg <= status_next;
            permit_out_reg <= prev_permit;
        end
    end

    assign out_valid          = out_valid_reg;
    assign window_phase       = win_reg.window_phase;
    assign message_code       = win_reg.message_code;
    assign show_request       = win_reg.show_request;
    assign hide_request       = win_reg.hide_request;
    assign audio_fault_enter  = win_reg.audio_enter;
    assign audio_fault_exit   = win_reg.audio_exit;
    assign pointer_fault_mode = win_reg.pointer_mode;
    assign remote_status      = status_out_reg;
    assign previous_permit    = permit_out_reg;

endmodule

### dv/tb.sv
module tb;
    import cfw_pkg::*;

    localparam logic ACT_TICK   = 1'b0;
    localparam logic ACT_PERMIT = 1'b1;
    localparam int   IDLE_LIMIT = 4000;
    localparam int   RANDOM_PER_SETTING = 305;

    typedef struct packed {
        logic [1:0] window_phase;
        logic [2:0] message_code;
        logic       show_request;
        logic       hide_request;
        logic       audio_fault_enter;
        logic       audio_fault_exit;
        logic       pointer_fault_mode;
        logic [1:0] remote_status;
        logic       previous_permit;
    } fault_view_t;

    logic                   clk;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic                   action = 1'b0;
    logic                   permit = 1'b0;
    logic [2:0]             drive_status = 3'd0;
    logic                   link_up = 1'b0;
    logic                   extension_present = 1'b0;
    logic [2:0]             battery_reading = 3'd0;
    logic                   window_anim_done = 1'b0;
    logic                   window_gone = 1'b0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [1:0]             window_phase;
    logic [2:0]             message_code;
    logic                   show_request;
    logic                   hide_request;
    logic                   audio_fault_enter;
    logic                   audio_fault_exit;
    logic                   pointer_fault_mode;
    logic [1:0]             remote_status;
    logic                   previous_permit;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_LOW_BATT;
    logic [7:0]             cfg_data = 8'd0;

    controller_fault_watcher_unit dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .action             (action),
        .permit             (permit),
        .drive_status       (drive_status),
        .link_up            (link_up),
        .extension_present  (extension_present),
        .battery_reading    (battery_reading),
        .window_anim_done   (window_anim_done),
        .window_gone        (window_gone),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .window_phase       (window_phase),
        .message_code       (message_code),
        .show_request       (show_request),
        .hide_request       (hide_request),
        .audio_fault_enter  (audio_fault_enter),
        .audio_fault_exit   (audio_fault_exit),
        .pointer_fault_mode (pointer_fault_mode),
        .remote_status      (remote_status),
        .previous_permit    (previous_permit),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    // predictor copy of the registers and state
    logic [2:0] low_batt     = LOW_BATT_RESET;
    logic [7:0] hold_ticks   = HOLD_RESET;
    logic [7:0] settle_ticks = IGNORE_RESET;
    logic       mon_en       = 1'b0;
    logic       link_seen    = 1'b0;
    logic [7:0] loss_count   = HOLD_RESET;
    logic [7:0] settle_count = 8'd0;
    logic [2:0] batt_held    = BATT_RESET;
    logic [1:0] rstat        = RS_OK;
    logic [1:0] phase        = PH_CODE_IDLE;
    logic [2:0] msg_shown    = MSG_NONE;
    logic       fresh_phase  = 1'b1;

    fault_view_t pending_views[$];
    fault_view_t want;
    bit          calm = 1'b0;
    int          err_count = 0;
    int          items_sent = 0;
    int          permits_sent = 0;
    int          settings_used = 0;
    int          windows_opened = 0;
    int          idle_cycles = 0;
    bit [3:0]    status_seen = '0;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic [2:0] fault_message(input logic [2:0] drive);
        if (drive >= DRV_FATAL && drive <= DRV_RETRY)
            return drive;
        case (rstat)
            RS_UNPL: return MSG_UNPLUGGED;
            RS_DISC: return MSG_DISCONNECT;
            RS_BATT: return MSG_BATTERY;
            default: return MSG_NONE;
        endcase
    endfunction

    function automatic void enter_phase(input logic [1:0] p);
        phase = p;
        fresh_phase = 1'b1;
    endfunction

    function automatic fault_view_t predict_view(input item_t it);
        fault_view_t v;
        logic        first;
        logic        rising;
        logic        waiting;
        logic        ok;
        logic [2:0]  msg;
        v = '0;
        if (it.action == ACT_PERMIT)
        begin
            v.previous_permit = mon_en;
            mon_en = it.permit;
            if (it.permit)
                loss_count = 8'd0;
            else
                rstat = RS_OK;
        end
        else
        begin
            if (!mon_en)
                rstat = RS_OK;
            else
            begin
                rising = it.link_up && !link_seen;
                link_seen = it.link_up;
                if (it.link_up)
                begin
                    batt_held = it.battery_reading;
                    loss_count = hold_ticks;
                end
                else if (loss_count != 8'd0)
                    loss_count--;
                waiting = (loss_count != 8'd0);
                if (rising)
                    settle_count = settle_ticks;
                if (settle_count != 8'd0)
                    settle_count--;
                if (settle_count == 8'd0)
                begin
                    ok = 1'b1;
                    if (it.link_up && !it.extension_present)
                    begin
                        rstat = RS_UNPL;
                        ok = 1'b0;
                    end
                    if (!waiting)
                    begin
                        rstat = (batt_held <= low_batt) ? RS_BATT : RS_DISC;
                        ok = 1'b0;
                    end
                    if (ok)
                        rstat = RS_OK;
                end
            end
            first = fresh_phase;
            fresh_phase = 1'b0;
            case (phase)
                PH_CODE_IDLE:
                begin
                    msg = fault_message(it.drive_status);
                    if (msg != MSG_NONE)
                    begin
                        msg_shown = msg;
                        enter_phase(PH_CODE_OPEN);
                        v.audio_fault_enter = 1'b1;
                    end
                end
                PH_CODE_OPEN:
                begin
                    if (first)
                        v.show_request = 1'b1;
                    if (it.window_anim_done)
                        enter_phase(PH_CODE_SHOW);
                    v.pointer_fault_mode = 1'b1;
                end
                PH_CODE_SHOW:
                begin
                    msg = fault_message(it.drive_status);
                    if (msg != MSG_NONE && msg != msg_shown)
                    begin
                        msg_shown = msg;
                        enter_phase(PH_CODE_OPEN);
                    end
                    if (msg == MSG_NONE)
                    begin
                        enter_phase(PH_CODE_CLOSE);
                        v.hide_request = 1'b1;
                        msg_shown = MSG_NONE;
                    end
                    v.pointer_fault_mode = 1'b1;
                end
                default:
                begin
                    if (it.window_gone)
                    begin
                        msg = fault_message(it.drive_status);
                        if (msg != MSG_NONE)
                        begin
                            msg_shown = msg;
                            enter_phase(PH_CODE_OPEN);
                        end
                        else
                        begin
                            v.audio_fault_exit = 1'b1;
                            enter_phase(PH_CODE_IDLE);
                        end
                    end
                    else
                        v.pointer_fault_mode = 1'b1;
                end
            endcase
        end
        v.window_phase = phase;
        v.message_code = msg_shown;
        v.remote_status = rstat;
        return v;
    endfunction

    function automatic item_t tick_item(input logic [2:0] drive, input logic link,
                                        input logic ext, input logic [2:0] batt,
                                        input logic anim, input logic gone);
        item_t it;
        it.action = ACT_TICK;
        it.permit = 1'($urandom_range(0, 1));
        it.drive_status = drive;
        it.link_up = link;
        it.extension_present = ext;
        it.battery_reading = batt;
        it.window_anim_done = anim;
        it.window_gone = gone;
        return it;
    endfunction

    function automatic item_t permit_item(input logic p);
        item_t it;
        it = item_t'($urandom());
        it.action = ACT_PERMIT;
        it.permit = p;
        return it;
    endfunction

    task automatic send_item(input item_t it);
        while (!calm && $urandom_range(0, 99) < 31)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid          <= 1'b1;
        action            <= it.action;
        permit            <= it.permit;
        drive_status      <= it.drive_status;
        link_up           <= it.link_up;
        extension_present <= it.extension_present;
        battery_reading   <= it.battery_reading;
        window_anim_done  <= it.window_anim_done;
        window_gone       <= it.window_gone;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_views.push_back(predict_view(it));
        items_sent++;
        if (it.action == ACT_PERMIT)
            permits_sent++;
    endtask

    task automatic drain_pipeline();
        in_valid <= 1'b0;
        while (pending_views.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_LOW_BATT: low_batt = val[2:0];
            CFG_HOLD:     hold_ticks = val;
            CFG_IGNORE:   settle_ticks = val;
            default:      ;
        endcase
    endtask

    task automatic apply_settings(input logic [2:0] lvl, input logic [7:0] hold_val,
                                  input logic [7:0] settle_val);
        drain_pipeline();
        write_reg(CFG_LOW_BATT, {5'd0, lvl});
        write_reg(CFG_HOLD, hold_val);
        write_reg(CFG_IGNORE, settle_val);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic compare_field(input string name, input logic [3:0] exp_val,
                                 input logic [3:0] got_val);
        if (got_val !== exp_val)
        begin
            $error("%s: expected %0d, got %0d", name, exp_val, got_val);
            err_count++;
        end
    endtask

    // window sequence driven by drive faults alone, monitoring still off
    task automatic test_drive_faults();
        send_item(tick_item(DRV_FATAL,   1'b1, 1'b1, 3'd4, 1'b0, 1'b0));
        send_item(tick_item(DRV_FATAL,   1'b1, 1'b1, 3'd4, 1'b0, 1'b0));
        send_item(tick_item(DRV_FATAL,   1'b1, 1'b1, 3'd4, 1'b1, 1'b0));
        send_item(tick_item(DRV_RETRY,   1'b0, 1'b0, 3'd0, 1'b0, 1'b1));
        send_item(tick_item(DRV_RETRY,   1'b1, 1'b1, 3'd4, 1'b1, 1'b0));
        send_item(tick_item(DRV_OTHER,   1'b1, 1'b1, 3'd4, 1'b0, 1'b1));
        send_item(tick_item(DRV_FATAL,   1'b1, 1'b1, 3'd4, 1'b1, 1'b0));
        send_item(tick_item(DRV_WRONG,   1'b1, 1'b1, 3'd4, 1'b0, 1'b1));
        send_item(tick_item(3'd7,        1'b1, 1'b1, 3'd7, 1'b1, 1'b0));
        send_item(tick_item(3'd6,        1'b1, 1'b1, 3'd4, 1'b0, 1'b0));
        send_item(tick_item(3'd5,        1'b1, 1'b1, 3'd4, 1'b0, 1'b1));
        send_item(tick_item(DRV_NO_DISK, 1'b1, 1'b1, 3'd4, 1'b0, 1'b0));
    endtask

    // permission on clears the loss counter, permission off forces ok
    task automatic test_permission();
        send_item(permit_item(1'b1));
        send_item(tick_item(DRV_OTHER, 1'b0, 1'b0, 3'd0, 1'b0, 1'b0));
        send_item(permit_item(1'b0));
        send_item(permit_item(1'b1));
    endtask

    // unplugged, battery, disconnect, hold of zero and the reconnect hold-off
    task automatic test_remote_status();
        apply_settings(3'd4, 8'd2, 8'd0);
        send_item(tick_item(DRV_OTHER, 1'b1, 1'b0, 3'd7, 1'b1, 1'b0));
        send_item(tick_item(DRV_OTHER, 1'b1, 1'b1, 3'd3, 1'b0, 1'b0));
        send_item(tick_item(DRV_OTHER, 1'b0, 1'b1, 3'd3, 1'b0, 1'b0));
        send_item(tick_item(DRV_OTHER, 1'b0, 1'b1, 3'd3, 1'b0, 1'b1));
        apply_settings(3'd0, 8'd0, 8'd0);
        send_item(tick_item(DRV_OTHER, 1'b1, 1'b1, 3'd5, 1'b0, 1'b1));
        send_item(tick_item(DRV_OTHER, 1'b1, 1'b1, 3'd0, 1'b1, 1'b0));
        apply_settings(3'd1, 8'd120, 8'd3);
        send_item(tick_item(DRV_OTHER, 1'b0, 1'b1, 3'd2, 1'b0, 1'b1));
        send_item(tick_item(DRV_OTHER, 1'b1, 1'b0, 3'd2, 1'b1, 1'b0));
        send_item(tick_item(DRV_OTHER, 1'b1, 1'b0, 3'd2, 1'b0, 1'b1));
    endtask

    // link outages of random length, persistent drive faults, occasional permission flips
    task automatic test_random_mix();
        logic [2:0] lvl_set[6]    = '{3'd1, 3'd0, 3'd4, 3'd2, 3'd3, 3'd4};
        logic [7:0] hold_set[6]   = '{8'd120, 8'd1, 8'd255, 8'd3, 8'd0, 8'd6};
        logic [7:0] settle_set[6] = '{8'd90, 8'd0, 8'd255, 8'd1, 8'd2, 8'd12};
        logic [2:0] drive_now;
        logic       link;
        logic       ext;
        logic [2:0] batt;
        int         outage_left;
        int         roll;
        drive_now = DRV_OTHER;
        outage_left = 0;
        for (int s = 0; s < 6; s++)
        begin
            apply_settings(lvl_set[s], hold_set[s], settle_set[s]);
            calm = (s == 3);
            send_item(permit_item(1'b1));
            for (int n = 0; n < RANDOM_PER_SETTING; n++)
            begin
                if (calm && n == 200)
                    calm = 1'b0;
                if ($urandom_range(0, 99) < 3)
                begin
                    send_item(permit_item($urandom_range(0, 99) < 80));
                    continue;
                end
                if (outage_left != 0)
                begin
                    outage_left--;
                    link = 1'b0;
                end
                else if ($urandom_range(0, 99) < 6)
                begin
                    outage_left = $urandom_range(1, 2 * hold_set[s] + 4);
                    link = 1'b0;
                end
                else
                    link = ($urandom_range(0, 99) < 95);
                if ($urandom_range(0, 99) < 15)
                begin
                    roll = $urandom_range(0, 99);
                    if (roll < 55)
                        drive_now = DRV_OTHER;
                    else if (roll < 90)
                        drive_now = 3'($urandom_range(DRV_FATAL, DRV_RETRY));
                    else
                        drive_now = 3'($urandom_range(5, 7));
                end
                ext = ($urandom_range(0, 99) < 85);
                if ($urandom_range(0, 99) < 10)
                    batt = 3'($urandom_range(5, 7));
                else
                    batt = 3'($urandom_range(0, 4));
                send_item(tick_item(drive_now, link, ext, batt,
                                    1'($urandom_range(0, 1)),
                                    ($urandom_range(0, 99) < 40)));
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_views.size() == 0)
            begin
                $error("result transfer with nothing expected");
                err_count++;
            end
            else
            begin
                want = pending_views.pop_front();
                compare_field("window_phase", 4'(want.window_phase), 4'(window_phase));
                compare_field("message_code", 4'(want.message_code), 4'(message_code));
                compare_field("show_request", 4'(want.show_request), 4'(show_request));
                compare_field("hide_request", 4'(want.hide_request), 4'(hide_request));
                compare_field("audio_fault_enter", 4'(want.audio_fault_enter),
                              4'(audio_fault_enter));
                compare_field("audio_fault_exit", 4'(want.audio_fault_exit),
                              4'(audio_fault_exit));
                compare_field("pointer_fault_mode", 4'(want.pointer_fault_mode),
                              4'(pointer_fault_mode));
                compare_field("remote_status", 4'(want.remote_status),
                              4'(remote_status));
                compare_field("previous_permit", 4'(want.previous_permit),
                              4'(previous_permit));
                if (want.show_request)
                    windows_opened++;
                status_seen[want.remote_status] = 1'b1;
            end
        end
        out_stall <= !calm && ($urandom_range(0, 99) < 31);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
            $display("Mismatches found");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_drive_faults();
        test_permission();
        test_remote_status();
        test_random_mix();
        drain_pipeline();
        repeat (8) @(posedge clk);
        $display("%0d items sent (%0d permission changes) over %0d register settings",
                 items_sent, permits_sent, settings_used);
        $display("%0d windows opened, remote status values seen (bit per code): %b",
                 windows_opened, status_seen);
        if (err_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
